FILE: hdl/fia_pkg.sv
// ----------------------------------------------------------------------------
// fia_pkg
// shared types and constants of the frame interval averager
// ----------------------------------------------------------------------------
package fia_pkg;

	localparam int HIST_DEPTH = 64;
	localparam int TIME_W     = 64;
	localparam int TICK_W     = 32;
	localparam int RATE_W     = 16;
	localparam int PTR_W      = $clog2(HIST_DEPTH);
	localparam int CNT_W      = $clog2(HIST_DEPTH + 1);
	localparam int SUM_W      = TICK_W + $clog2(HIST_DEPTH);
	localparam int STEP_W     = $clog2(SUM_W);

	localparam int          PADDR_W      = 3;
	localparam logic        REG_TPS_IDX  = 1'b0;
	localparam logic [31:0] TPS_RESET    = 32'd1000;

	// one request handed from the front to the back
	typedef struct packed {
		logic              first;
		logic [TICK_W-1:0] interval;
	} cmd_t;

	// one finished result
	typedef struct packed {
		logic [TICK_W-1:0] average_ticks;
		logic [RATE_W-1:0] frame_rate;
		logic [CNT_W-1:0]  samples_held;
		logic              sample_accepted;
	} res_t;

endpackage

FILE: hdl/fia_front.sv
// ----------------------------------------------------------------------------
// fia_front
// takes timestamps, forms the saturated interval since the previous one
// ----------------------------------------------------------------------------
module fia_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [fia_pkg::TIME_W-1:0] current_time,
	input  logic                       cmd_full,
	output logic                       cmd_we,
	output fia_pkg::cmd_t              cmd
);
	import fia_pkg::*;

	logic [TIME_W-1:0] prev_time_q;
	logic              started_q;
	logic [TIME_W-1:0] diff;

	assign cmd_we = push & ~cmd_full;
	assign diff   = current_time - prev_time_q;

	always_comb begin
		cmd.first    = ~started_q;
		// saturate the wrapped difference to the interval width
		cmd.interval = (|diff[TIME_W-1:TICK_W]) ? '1 : diff[TICK_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_time_q <= '0;
			started_q   <= 1'b0;
		end else if (cmd_we) begin
			prev_time_q <= current_time;
			started_q   <= 1'b1;
		end
	end

endmodule

FILE: hdl/fia_cmd_queue.sv
// ----------------------------------------------------------------------------
// fia_cmd_queue
// two-entry queue between front and back
// ----------------------------------------------------------------------------
module fia_cmd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  fia_pkg::cmd_t wr_data,
	output logic          full,
	input  logic          rd_en,
	output logic          valid,
	output fia_pkg::cmd_t rd_data
);
	import fia_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;

	assign full    = (fill_q == 2'd2);
	assign valid   = (fill_q != 2'd0);
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			fill_q <= fill_q + 2'(wr_en) - 2'(rd_en);
		end
	end

endmodule

FILE: hdl/fia_back.sv
// ----------------------------------------------------------------------------
// fia_back
// outlier gate, interval history, rate window and serial mean divider
// ----------------------------------------------------------------------------
module fia_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [fia_pkg::TICK_W-1:0] tps,
	input  logic                       cmd_valid,
	input  fia_pkg::cmd_t              cmd,
	output logic                       cmd_pop,
	output logic                       res_valid,
	input  logic                       res_pop,
	output fia_pkg::res_t              res
);
	import fia_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_GATE = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0]        state_q;
	logic [TICK_W-1:0] hist_mem [HIST_DEPTH];
	logic [TICK_W-1:0] old_q;
	logic [TICK_W-1:0] interval_q;
	logic              acc_q;
	logic [PTR_W-1:0]  ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic [SUM_W-1:0]  sum_q;
	logic [TICK_W-1:0] avg_q;
	logic [RATE_W-1:0] frames_q;
	logic [TICK_W:0]   wticks_q;
	logic [RATE_W-1:0] rate_q;
	logic [SUM_W-1:0]  quo_q;
	logic [CNT_W-1:0]  rem_q;
	logic [STEP_W-1:0] step_q;
	logic              res_valid_q;
	res_t              res_q;

	logic [TICK_W-1:0] dev;
	logic              pass;
	logic              hist_full;
	logic [SUM_W-1:0]  sum_new;
	logic [CNT_W-1:0]  count_new;
	logic [TICK_W:0]   wticks_sum;
	logic [RATE_W-1:0] frames_inc;
	logic [CNT_W:0]    trial;
	logic              qbit;
	logic [SUM_W-1:0]  quo_next;
	logic              res_free;

	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign res_free  = ~res_valid_q | res_pop;
	assign cmd_pop   = (state_q == ST_IDLE) & cmd_valid;

	always_comb begin
		dev        = (interval_q >= avg_q) ? interval_q - avg_q : avg_q - interval_q;
		pass       = dev < tps;
		hist_full  = (count_q == CNT_W'(HIST_DEPTH));
		sum_new    = sum_q + SUM_W'(interval_q) - (hist_full ? SUM_W'(old_q) : '0);
		count_new  = hist_full ? count_q : count_q + 1'b1;
		wticks_sum = wticks_q + (TICK_W+1)'(interval_q);
		frames_inc = (&frames_q) ? frames_q : frames_q + 1'b1;
		// one restoring step per cycle
		trial      = {rem_q, quo_q[SUM_W-1]};
		qbit       = trial >= {1'b0, count_q};
		quo_next   = {quo_q[SUM_W-2:0], qbit};
	end

	// history memory, read data registered
	always_ff @(posedge clk) begin
		if (state_q == ST_GATE && pass) begin
			hist_mem[ptr_q] <= interval_q;
		end
		old_q <= hist_mem[ptr_q];
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			interval_q <= cmd.interval;
		end
		if (state_q == ST_GATE) begin
			quo_q  <= sum_new;
			rem_q  <= '0;
			step_q <= '0;
		end else if (state_q == ST_DIV) begin
			quo_q  <= quo_next;
			rem_q  <= qbit ? CNT_W'(trial - {1'b0, count_q}) : trial[CNT_W-1:0];
			step_q <= step_q + 1'b1;
		end
		if (state_q == ST_OUT && res_free) begin
			res_q.average_ticks   <= avg_q;
			res_q.frame_rate      <= rate_q;
			res_q.samples_held    <= count_q;
			res_q.sample_accepted <= acc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			acc_q       <= 1'b0;
			ptr_q       <= '0;
			count_q     <= '0;
			sum_q       <= '0;
			avg_q       <= '0;
			frames_q    <= '0;
			wticks_q    <= '0;
			rate_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_pop) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						acc_q   <= 1'b0;
						state_q <= cmd.first ? ST_OUT : ST_GATE;
					end
				end
				ST_GATE: begin
					acc_q <= pass;
					if (wticks_sum > (TICK_W+1)'(tps)) begin
						rate_q   <= frames_inc;
						frames_q <= '0;
						wticks_q <= '0;
					end else begin
						frames_q <= frames_inc;
						wticks_q <= wticks_sum;
					end
					if (pass) begin
						sum_q   <= sum_new;
						count_q <= count_new;
						ptr_q   <= (ptr_q == PTR_W'(HIST_DEPTH - 1)) ? '0 : ptr_q + 1'b1;
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_DIV: begin
					if (step_q == STEP_W'(SUM_W - 1)) begin
						avg_q   <= quo_next[TICK_W-1:0];
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (res_free) begin
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: hdl/frame_interval_averager_core.sv
// ----------------------------------------------------------------------------
// frame_interval_averager_core
// moving-average frame timer over per-frame tick counter timestamps
// ----------------------------------------------------------------------------
// Each request is the tick counter value at one frame; each request yields
// exactly one result. The first request after reset only records the time.
// Later requests form the elapsed ticks (wrapping, saturated to 32 bits), gate
// them against the current average by one second (ticks_per_second), keep up
// to 64 intervals and report their truncated mean plus the frame count of the
// last completed one-second window. In the back end only an accepted interval
// runs the 38-step bit-serial divider forming the mean from the history sum.
// A two-entry queue lets the front keep taking timestamps while the back end
// works, and the result register lets the next request start while a result
// waits to be popped. The history memory needs no clearing pass: a slot is
// only read back once the history is full. ticks_per_second sits at byte
// address 0; the user must write it only while idle, and the block itself
// does not enforce this.
// ----------------------------------------------------------------------------
module frame_interval_averager_core (
	input  logic                        clk,
	input  logic                        arst_n,
	// request side
	input  logic                        push,
	output logic                        full,
	input  logic [fia_pkg::TIME_W-1:0]  current_time,
	// result side
	output logic                        empty,
	input  logic                        pop,
	output logic [fia_pkg::TICK_W-1:0]  average_ticks,
	output logic [fia_pkg::RATE_W-1:0]  frame_rate,
	output logic [fia_pkg::CNT_W-1:0]   samples_held,
	output logic                        sample_accepted,
	// configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [fia_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import fia_pkg::*;

	logic [TICK_W-1:0] tps_q;
	logic              cmd_we;
	logic              cmd_full;
	logic              cmd_valid;
	logic              cmd_pop;
	cmd_t              cmd_in;
	cmd_t              cmd_out;
	logic              res_valid;
	res_t              res;

	// register file: one register, word index on paddr[2]
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_TPS_IDX) ? tps_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= TPS_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_TPS_IDX) begin
			tps_q <= pwdata;
		end
	end

	// front: timestamp tracking and interval forming
	fia_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.current_time (current_time),
		.cmd_full     (cmd_full),
		.cmd_we       (cmd_we),
		.cmd          (cmd_in)
	);

	assign full = cmd_full;

	// decoupling queue
	fia_cmd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_we),
		.wr_data (cmd_in),
		.full    (cmd_full),
		.rd_en   (cmd_pop),
		.valid   (cmd_valid),
		.rd_data (cmd_out)
	);

	// back: gate, history, window, mean
	fia_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tps       (tps_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.res_valid (res_valid),
		.res_pop   (pop),
		.res       (res)
	);

	assign empty           = ~res_valid;
	assign average_ticks   = res.average_ticks;
	assign frame_rate      = res.frame_rate;
	assign samples_held    = res.samples_held;
	assign sample_accepted = res.sample_accepted;

	// history never holds more than its depth
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> samples_held <= CNT_W'(HIST_DEPTH))
		else $error("samples_held above history depth");

	// an accepted interval always leaves the history non-empty
	a_acc_held: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && sample_accepted) |-> samples_held != '0)
		else $error("accepted sample with empty history");

	// empty history reports a zero mean
	a_empty_avg: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && samples_held == '0) |-> average_ticks == '0)
		else $error("nonzero mean with empty history");

endmodule

FILE: tb/frame_interval_averager_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_interval_averager_core_tb
// self-checking bench for the moving-average frame timer
// ----------------------------------------------------------------------------
// Timestamps are queued by the stimulus process and handed to the block by a
// clocked driver with random push gaps; a clocked monitor pops results with
// random stalls. Every accepted request runs through a local frame timer model
// (interval, outlier gate, 64-entry history, truncated mean, one-second frame
// window), and every popped result is compared field by field with the oldest
// prediction. ticks_per_second is rewritten between phases while the block is
// idle, including both ends of its range, and read back over APB.
// ----------------------------------------------------------------------------
module frame_interval_averager_core_tb;
	import fia_pkg::*;

	localparam int                 LIMIT_CYCLES = 3_000_000;
	// register map: ticks_per_second at index 0, index 1 is unmapped
	localparam logic [PADDR_W-1:0] TPS_ADDR     = {REG_TPS_IDX, 2'b00};
	localparam logic [PADDR_W-1:0] NOREG_ADDR   = {~REG_TPS_IDX, 2'b00};
	localparam logic [31:0]        TPS_MAX      = 32'hFFFF_FFFF;
	localparam logic [63:0]        TICK_SAT     = 64'h0000_0000_FFFF_FFFF;
	localparam logic [RATE_W-1:0]  RATE_SAT     = '1;

	// dut connections, all inputs known from time zero
	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               push         = 1'b0;
	logic               full;
	logic [TIME_W-1:0]  current_time = '0;
	logic               empty;
	logic               pop          = 1'b0;
	logic [TICK_W-1:0]  average_ticks;
	logic [RATE_W-1:0]  frame_rate;
	logic [CNT_W-1:0]   samples_held;
	logic               sample_accepted;
	logic               psel         = 1'b0;
	logic               penable      = 1'b0;
	logic               pwrite       = 1'b0;
	logic [PADDR_W-1:0] paddr        = '0;
	logic [31:0]        pwdata       = '0;
	logic [31:0]        prdata;
	logic               pready;

	// timestamps waiting for the driver, predictions waiting for a pop
	logic [TIME_W-1:0]  pending_stamps[$];
	res_t               expected_results[$];

	int                 err_count   = 0;
	int                 cycle_count = 0;
	int                 push_gap    = 0;
	int                 pop_gap     = 0;
	bit                 quiet       = 1'b0;   // no idling on either side
	logic [TIME_W-1:0]  next_stamp  = '0;     // last timestamp queued

	// frame timer model state
	logic [31:0]        tm_tps = TPS_RESET;
	logic [TIME_W-1:0]  tm_prev;
	logic               tm_started;
	logic [TICK_W-1:0]  tm_hist[0:HIST_DEPTH-1];
	logic [PTR_W-1:0]   tm_ptr;
	logic [CNT_W-1:0]   tm_count;
	logic [63:0]        tm_sum;
	logic [TICK_W-1:0]  tm_avg;
	logic [RATE_W-1:0]  tm_wframes;
	logic [63:0]        tm_wticks;
	logic [RATE_W-1:0]  tm_rate;

	frame_interval_averager_core uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.current_time   (current_time),
		.empty          (empty),
		.pop            (pop),
		.average_ticks  (average_ticks),
		.frame_rate     (frame_rate),
		.samples_held   (samples_held),
		.sample_accepted(sample_accepted),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	always #10 clk = ~clk;

	// advance the frame timer by one timestamp and return the result it reports
	function automatic res_t frame_timer_step(input logic [TIME_W-1:0] stamp);
		logic [63:0]       diff;
		logic [TICK_W-1:0] ivl;
		logic [63:0]       dev;
		res_t              r;
		r.sample_accepted = 1'b0;
		if (!tm_started) begin
			// first timestamp after reset only records the time
			tm_prev    = stamp;
			tm_started = 1'b1;
		end else begin
			// elapsed ticks wrap with the counter, then clip to 32 bits
			diff    = stamp - tm_prev;
			ivl     = (diff > TICK_SAT) ? TICK_SAT[TICK_W-1:0] : diff[TICK_W-1:0];
			tm_prev = stamp;
			dev     = (ivl >= tm_avg) ? 64'(ivl) - 64'(tm_avg) : 64'(tm_avg) - 64'(ivl);
			// outlier gate: must lie strictly within one second of the mean
			if (dev < 64'(tm_tps)) begin
				r.sample_accepted = 1'b1;
				if (tm_count >= HIST_DEPTH)
					tm_sum = tm_sum - 64'(tm_hist[tm_ptr]);   // drop the oldest
				else
					tm_count = tm_count + 1'b1;
				tm_hist[tm_ptr] = ivl;
				tm_sum          = tm_sum + 64'(ivl);
				tm_ptr          = (tm_ptr == PTR_W'(HIST_DEPTH - 1)) ? '0 : tm_ptr + 1'b1;
			end
			// one-second frame window, frame count saturates
			if (tm_wframes != RATE_SAT)
				tm_wframes = tm_wframes + 1'b1;
			tm_wticks = tm_wticks + 64'(ivl);
			if (tm_wticks > 64'(tm_tps)) begin
				tm_rate    = tm_wframes;
				tm_wframes = '0;
				tm_wticks  = '0;
			end
			tm_avg = (tm_count != 0) ? TICK_W'(tm_sum / 64'(tm_count)) : '0;
		end
		r.average_ticks = tm_avg;
		r.frame_rate    = tm_rate;
		r.samples_held  = tm_count;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			err_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	// monitor: take predictions on accepted requests, check popped results
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("frame_interval_averager_core_tb: done, errors");
			$finish;
		end else if (arst_n) begin
			if (push && !full) begin
				expected_results.push_back(frame_timer_step(current_time));
				void'(pending_stamps.pop_front());
			end
			if (pop && !empty) begin
				if (expected_results.size() == 0) begin
					err_count++;
					$display("%0t: result popped with no request outstanding, actual avg %0d",
						$time, average_ticks);
				end else begin
					res_t want;
					want = expected_results.pop_front();
					check_field("average_ticks", want.average_ticks, average_ticks);
					check_field("frame_rate", want.frame_rate, frame_rate);
					check_field("samples_held", want.samples_held, samples_held);
					check_field("sample_accepted", want.sample_accepted, sample_accepted);
				end
			end
		end
	end

	// request driver: random push gaps unless quiet
	always @(negedge clk) begin
		if (push_gap > 0) begin
			push_gap--;
			push <= 1'b0;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			push_gap = $urandom_range(0, 7);
			push <= 1'b0;
		end else if (arst_n && pending_stamps.size() != 0) begin
			push         <= 1'b1;
			current_time <= pending_stamps[0];
		end else begin
			push <= 1'b0;
		end
	end

	// result side: pop with random stall bursts
	always @(negedge clk) begin
		if (pop_gap > 0) begin
			pop_gap--;
			pop <= 1'b0;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			pop_gap = $urandom_range(0, 7);
			pop <= 1'b0;
		end else begin
			pop <= arst_n;
		end
	end

	task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		// unmapped index leaves the register alone
		if (addr[PADDR_W-1:2] == REG_TPS_IDX)
			tm_tps = data;
	endtask

	task automatic reg_check(input logic [PADDR_W-1:0] addr, input logic [31:0] want);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== want) begin
			err_count++;
			$display("%0t: ticks_per_second readback mismatch, expected %0d, actual %0d",
				$time, want, prdata);
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic queue_stamp(input logic [TIME_W-1:0] stamp);
		next_stamp = stamp;
		pending_stamps.push_back(stamp);
	endtask

	task automatic queue_delta(input logic [63:0] delta);
		queue_stamp(next_stamp + delta);
	endtask

	// wait until the driver queue has gone out
	task automatic wait_sent();
		while (pending_stamps.size() != 0)
			@(posedge clk);
	endtask

	// wait until every request has come back; block is idle after that
	task automatic wait_idle();
		do
			@(posedge clk);
		while (pending_stamps.size() != 0 || expected_results.size() != 0);
	endtask

	// one setting of ticks_per_second, then batches of timestamps built
	// around the current mean so that most intervals pass the gate
	task automatic run_phase(input logic [31:0] tps_val, input int batches);
		logic [63:0] center;
		logic [63:0] spread;
		logic [63:0] v;
		int          pick;
		wait_idle();
		reg_write(TPS_ADDR, tps_val);
		reg_check(TPS_ADDR, tps_val);
		repeat (batches) begin
			center = 64'(tm_avg);
			spread = (tps_val > 2000) ? 64'd2000 : 64'(tps_val) - 1;
			repeat (20) begin
				pick = $urandom_range(0, 99);
				if (pick < 70) begin
					// well-formed frame: mean plus jitter inside the gate
					v = center + 64'($urandom_range(0, 32'(2 * spread)));
					queue_delta((v > spread) ? v - spread : 64'd0);
				end else if (pick < 80)
					queue_delta(64'($urandom));
				else if (pick < 85)
					queue_stamp({$urandom, $urandom});
				else if (pick < 89)
					queue_delta(64'd0);
				else if (pick < 93)
					queue_delta(center + 64'(tps_val) - 1);   // just inside the gate
				else if (pick < 96)
					queue_delta(center + 64'(tps_val));       // just outside the gate
				else
					queue_delta({30'd0, 2'($urandom_range(1, 3)), $urandom});   // clipped
			end
			wait_sent();
		end
	endtask

	initial begin
		logic [31:0] tps_rand;

		// model reset state
		tm_prev    = '0;
		tm_started = 1'b0;
		tm_ptr     = '0;
		tm_count   = '0;
		tm_sum     = '0;
		tm_avg     = '0;
		tm_wframes = '0;
		tm_wticks  = '0;
		tm_rate    = '0;
		for (int i = 0; i < HIST_DEPTH; i++)
			tm_hist[i] = '0;

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		reg_check(TPS_ADDR, TPS_RESET);

		// directed: first timestamp only records, gate edges at zero mean,
		// counter wrap, clipping to 32 bits, extremes of the timestamp
		queue_stamp(64'hFFFF_FFFF_FFFF_FFF0);
		queue_delta(64'd1000);                   // exactly one second off, wraps
		queue_delta(64'd999);                    // one tick inside
		queue_delta(64'd0);
		queue_delta(64'd1499);                   // one second above mean 499
		queue_delta(64'd1498);
		queue_delta(64'h0000_0001_0000_0000);    // clipped
		queue_delta(TICK_SAT);                   // largest unclipped interval
		queue_delta(64'h0000_0100_0000_0000);
		queue_stamp(64'hFFFF_FFFF_FFFF_FFFF);
		queue_stamp(64'h0000_0000_0000_0000);    // wrap by one tick
		queue_stamp(64'h8000_0000_0000_0000);
		queue_stamp(64'h7FFF_FFFF_FFFF_FFFF);    // wraps to a huge interval
		repeat (10) queue_delta(64'd16);
		wait_idle();

		// write to the unmapped index must not disturb the register
		reg_write(NOREG_ADDR, $urandom);
		reg_check(TPS_ADDR, TPS_RESET);

		run_phase(TPS_RESET, 12);
		run_phase(32'd1, 5);
		run_phase(TPS_MAX, 10);
		run_phase(32'($urandom_range(2, 1_000_000)), 12);

		// fill the history with 100s so the mean is nonzero, then under the
		// smallest second zero intervals are all rejected and never close
		// the window, so the frame count keeps climbing
		repeat (HIST_DEPTH) queue_delta(64'd100);
		wait_idle();
		quiet = 1'b1;
		reg_write(TPS_ADDR, 32'd1);
		repeat (64) queue_delta(64'd0);
		queue_delta(64'd5);                      // closes the window, latches the count
		wait_idle();
		quiet = 1'b0;

		run_phase(32'($urandom_range(2, 100_000)), 10);

		// closing stretch with no idling
		tps_rand = $urandom;
		if (tps_rand == 0)
			tps_rand = 32'd1;
		wait_idle();
		quiet = 1'b1;
		run_phase(tps_rand, 10);

		wait_idle();
		repeat (60) @(posedge clk);
		if (err_count == 0)
			$display("frame_interval_averager_core_tb: done, clean");
		else
			$display("frame_interval_averager_core_tb: done, errors");
		$finish;
	end

endmodule

FILE: files.f
hdl/fia_pkg.sv
hdl/fia_front.sv
hdl/fia_cmd_queue.sv
hdl/fia_back.sv
hdl/frame_interval_averager_core.sv
tb/frame_interval_averager_core_tb.sv
